/* rtl/core/svmrbf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmrbf_pkg
// shared constants and table generator for the rbf kernel classifier
// ----------------------------------------------------------------------------
package svmrbf_pkg;

  localparam int SV_DEPTH_DEF      = 256;
  localparam int DIMS_DEF          = 4;
  localparam int EXP_LUT_DEPTH_DEF = 256;

  localparam int FEAT_W   = 16;
  localparam int IDX_W    = 8;
  localparam int KERN_W   = 17;
  localparam int SDATA_W  = 88;
  localparam int MDATA_W  = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] GAMMA_RST    = 16'd64;
  localparam logic [15:0] BIAS_RHO_RST = 16'hFF81;

  localparam logic [CFG_IDX_W-1:0] REG_GAMMA    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_RHO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SV_COUNT = 2'd2;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  // one term of the series, divided by its constant order
  function automatic logic [63:0] div_order(input logic [63:0] v, input int k);
    logic [63:0] q;
    q = v;
    unique case (k)
      1:  q = v;
      2:  q = v / 2;
      3:  q = v / 3;
      4:  q = v / 4;
      5:  q = v / 5;
      6:  q = v / 6;
      7:  q = v / 7;
      8:  q = v / 8;
      9:  q = v / 9;
      10: q = v / 10;
      11: q = v / 11;
      12: q = v / 12;
      default: q = v;
    endcase
    return q;
  endfunction

  // exp(-i*step) in unsigned q.16, step ratio h given in q.32
  function automatic logic [KERN_W-1:0] exp_value(input logic [63:0] h, input int idx);
    logic [127:0] t;
    logic [127:0] r;
    logic [127:0] e;
    t = 128'd1 << 32;
    r = t;
    e = 128'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      t = {64'd0, div_order(64'((t * h) >> 32), k)};
      if ((k % 2) == 1) r = r - t;
      else r = r + t;
    end
    for (int i = 1; i <= idx; i++) begin
      e = ((e * r) + (128'd1 << 31)) >> 32;
    end
    return KERN_W'((e + (128'd1 << 15)) >> 16);
  endfunction

endpackage

/* rtl/core/svmrbf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmrbf_ram
// simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module svmrbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/svm_rbf_decision.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_rbf_decision
// support vector classifier with rbf kernel, q8.8 inputs, q16.16 decision
// ----------------------------------------------------------------------------
// s_* takes requests: tuser[0] is the operation, a load writes weight and
// features into slot entry_index, a classify brings a sample.
// m_* returns one decision per classify, none per load.
// cfg_* writes gamma, bias_rho and sv_count; write only while idle.
// a classify walks the support vector rams one entry per cycle through a
// seven stage read/kernel/accumulate pipeline over the first n entries,
// n = min(sv_count, SV_DEPTH).
// one request is in work at a time; s_tready is low until the decision has
// moved into the output register.
// the output register holds the decision while the receiver stalls, and
// the next request is accepted meanwhile.
// reset restores the register defaults and empties the output; table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module svm_rbf_decision #(
  parameter int SV_DEPTH      = svmrbf_pkg::SV_DEPTH_DEF,
  parameter int DIMS          = svmrbf_pkg::DIMS_DEF,
  parameter int EXP_LUT_DEPTH = svmrbf_pkg::EXP_LUT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // entry_index, weight, feature_a, feature_b, feature_c, feature_d
  input  logic [svmrbf_pkg::SDATA_W-1:0]      s_tdata,
  // operation
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // decision, class_label, zero fill
  output logic [svmrbf_pkg::MDATA_W-1:0]      m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [svmrbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svmrbf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW  = $clog2(SV_DEPTH > 1 ? SV_DEPTH : 2);
  localparam int CW  = $clog2(SV_DEPTH + 1);
  localparam int LW  = $clog2(EXP_LUT_DEPTH);
  localparam int FW  = svmrbf_pkg::FEAT_W;
  localparam int KW  = svmrbf_pkg::KERN_W;
  localparam int DW  = 32 + $clog2(DIMS + 1);
  localparam int PW  = DW + 16;
  localparam logic [63:0] LUT_H = (64'd1 << 36) / EXP_LUT_DEPTH;
  localparam logic [PW-1:0] P_LIMIT = PW'(64'd16 << 24);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  logic [15:0] gamma;
  logic [15:0] bias_rho;
  logic [8:0]  sv_count;

  // exp table, built at elaboration
  logic [KW-1:0] exp_lut [EXP_LUT_DEPTH];
  for (genvar g = 0; g < EXP_LUT_DEPTH; g++) begin : g_lut
    localparam logic [KW-1:0] LUT_VAL = svmrbf_pkg::exp_value(LUT_H, g);
    assign exp_lut[g] = LUT_VAL;
  end

  logic s_acc;
  logic load_we;
  logic [AW-1:0] load_addr;
  logic [CW-1:0] cnt;
  logic [CW-1:0] n_lim;
  logic issue;
  logic [5:0] pv;
  logic out_load;

  logic signed [FW-1:0] x [DIMS];
  logic [15:0] w_rd;
  logic [63:0] f_rd;

  logic [31:0] sq [DIMS];
  logic signed [15:0] w1, w2, w3, w4;
  logic [DW-1:0] sq_sum;
  logic [DW-1:0] sq_sum_next;
  logic [PW-1:0] p;
  logic [KW-1:0] kern;
  logic [LW-1:0] lut_idx;
  logic [PW+LW:0] lut_scaled;
  logic signed [33:0] prod;
  logic signed [31:0] sum;
  logic signed [34:0] prod_rnd;
  logic signed [33:0] sum_ext;
  logic signed [33:0] dec_ext;
  logic signed [31:0] dec;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_acc     = s_tvalid && s_tready;

  assign load_we   = s_acc && (s_tuser[0] == svmrbf_pkg::OP_LOAD) &&
                     ({24'd0, s_tdata[7:0]} < SV_DEPTH);
  assign load_addr = AW'(s_tdata[7:0]);

  assign n_lim = (32'(sv_count) > SV_DEPTH) ? CW'(SV_DEPTH) : CW'(sv_count);
  assign issue = (state == ST_RUN) && (cnt < n_lim);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  svmrbf_ram #(.WIDTH(16), .DEPTH(SV_DEPTH)) u_weights (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (s_tdata[23:8]),
    .raddr (cnt[AW-1:0]),
    .rdata (w_rd)
  );

  svmrbf_ram #(.WIDTH(64), .DEPTH(SV_DEPTH)) u_features (
    .clk   (clk),
    .we    (load_we),
    .waddr (load_addr),
    .wdata (s_tdata[87:24]),
    .raddr (cnt[AW-1:0]),
    .rdata (f_rd)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma    <= svmrbf_pkg::GAMMA_RST;
      bias_rho <= svmrbf_pkg::BIAS_RHO_RST;
      sv_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        svmrbf_pkg::REG_GAMMA:    gamma    <= cfg_data;
        svmrbf_pkg::REG_BIAS_RHO: bias_rho <= cfg_data;
        svmrbf_pkg::REG_SV_COUNT: sv_count <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      pv       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      pv <= {pv[4:0], issue};
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_acc && (s_tuser[0] == svmrbf_pkg::OP_CLASSIFY)) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            cnt <= cnt + CW'(1);
          end else if (pv == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (s_acc) begin
      for (int k = 0; k < DIMS; k++) begin
        x[k] <= s_tdata[24 + FW*k +: FW];
      end
    end
  end

  always_comb begin
    sq_sum_next = '0;
    for (int k = 0; k < DIMS; k++) begin
      sq_sum_next = sq_sum_next + DW'(sq[k]);
    end
  end

  assign lut_scaled = (PW+LW+1)'(p[27:0]) * (PW+LW+1)'(EXP_LUT_DEPTH);
  assign lut_idx    = LW'(lut_scaled >> 28);

  // kernel pipeline
  always_ff @(posedge clk) begin
    logic signed [FW:0] d;
    logic [FW-1:0] a;
    if (pv[0]) begin
      for (int k = 0; k < DIMS; k++) begin
        d = {x[k][FW-1], x[k]} - {f_rd[FW*k+FW-1], f_rd[FW*k +: FW]};
        a = d[FW] ? FW'(-d) : FW'(d);
        sq[k] <= a * a;
      end
      w1 <= w_rd;
    end
    if (pv[1]) begin
      sq_sum <= sq_sum_next;
      w2     <= w1;
    end
    if (pv[2]) begin
      p  <= sq_sum * PW'(gamma);
      w3 <= w2;
    end
    if (pv[3]) begin
      kern <= (p >= P_LIMIT) ? '0 : exp_lut[lut_idx];
      w4   <= w3;
    end
    if (pv[4]) begin
      prod <= 34'(w4) * $signed({1'b0, kern});
    end
  end

  assign prod_rnd = (35'(prod) + 35'sd128) >>> 8;
  assign sum_ext  = 34'(sum) + 34'(prod_rnd);

  always_ff @(posedge clk) begin
    if (s_acc) begin
      sum <= '0;
    end else if (pv[5]) begin
      if (sum_ext > 34'sh0_7FFF_FFFF) sum <= 32'sh7FFF_FFFF;
      else if (sum_ext < -34'sh0_8000_0000) sum <= 32'sh8000_0000;
      else sum <= sum_ext[31:0];
    end
  end

  assign dec_ext = 34'(sum) - (34'($signed(bias_rho)) <<< 8);
  always_comb begin
    if (dec_ext > 34'sh0_7FFF_FFFF) dec = 32'sh7FFF_FFFF;
    else if (dec_ext < -34'sh0_8000_0000) dec = 32'sh8000_0000;
    else dec = dec_ext[31:0];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {7'd0, (dec > 32'sd0), dec};
    end
  end

  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    (pv != '0) |-> (state == ST_RUN))
    else $error("pipeline active outside a classification");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issue |-> (cnt < CW'(SV_DEPTH)))
    else $error("read issued past the table");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("decision not presented");

  a_classify_run: assert property (@(posedge clk) disable iff (rst)
    (s_acc && s_tuser[0] == svmrbf_pkg::OP_CLASSIFY) |=> (state == ST_RUN))
    else $error("classification did not start");

endmodule

/* test/svm_rbf_decision_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_rbf_decision_tb
// Self-checking bench for the rbf kernel support vector classifier. It loads
// support vectors and sends samples over the slave stream, and rewrites
// gamma, rho and the vector count between phases while the block is idle.
// A scoreboard class predicts each decision and checks the master stream,
// with random gaps on the sender side and random stalls on the receiver side.
// ----------------------------------------------------------------------------
module svm_rbf_decision_tb;

  localparam int TABLE_N = 256;
  localparam int LUT_N = 256;
  localparam logic [svmrbf_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_REQUESTS = 77;

  typedef struct {
    logic signed [31:0] decision;
    logic               class_label;
  } decision_t;

  class decision_scoreboard;
    logic [16:0] exp_tab [LUT_N];
    logic [15:0] weights [TABLE_N];
    logic [63:0] features [TABLE_N];
    logic [15:0] gamma_q;
    logic [15:0] rho_q;
    logic [8:0]  count_q;
    decision_t   expected_q[$];
    int errors, checked, loads, samples;

    function new();
      longint unsigned h, t, r, e;
      h = (64'd16 << 32) / LUT_N;
      t = 64'd1 << 32;
      r = t;
      for (int k = 1; k <= 12; k++) begin
        t = ((t * h) >> 32) / k;
        if (k % 2 == 1) r = r - t;
        else r = r + t;
      end
      e = 64'd1 << 32;
      for (int i = 0; i < LUT_N; i++) begin
        if (i > 0) e = (e * r + (64'd1 << 31)) >> 32;
        exp_tab[i] = 17'((e + (64'd1 << 15)) >> 16);
      end
      foreach (weights[i]) begin
        weights[i] = '0;
        features[i] = '0;
      end
      gamma_q = svmrbf_pkg::GAMMA_RST;
      rho_q = svmrbf_pkg::BIAS_RHO_RST;
      count_q = '0;
    endfunction

    function void write_reg(logic [svmrbf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
      case (idx)
        svmrbf_pkg::REG_GAMMA: gamma_q = value;
        svmrbf_pkg::REG_BIAS_RHO: rho_q = value;
        svmrbf_pkg::REG_SV_COUNT: count_q = value[8:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note_request(logic op, logic [svmrbf_pkg::SDATA_W-1:0] data);
      longint sum, prod, d, dec;
      longint unsigned sq_sum, p, kern, g;
      int n;
      decision_t res;
      if (op == svmrbf_pkg::OP_LOAD) begin
        weights[data[7:0]] = data[23:8];
        features[data[7:0]] = data[87:24];
        loads++;
        return;
      end
      samples++;
      n = (count_q > TABLE_N) ? TABLE_N : count_q;
      g = gamma_q;
      sum = 0;
      for (int i = 0; i < n; i++) begin
        sq_sum = 0;
        for (int k = 0; k < 4; k++) begin
          d = longint'($signed(data[24 + 16*k +: 16])) -
              longint'($signed(features[i][16*k +: 16]));
          sq_sum += longint'(d * d);
        end
        p = sq_sum * g;
        if (p >= (64'd16 << 24)) kern = 0;
        else kern = exp_tab[(p * LUT_N) >> 28];
        prod = longint'($signed(weights[i])) * longint'(kern);
        sum = clamp32(sum + ((prod + 128) >>> 8));
      end
      dec = clamp32(sum - longint'($signed(rho_q)) * 256);
      res.decision = 32'(dec);
      res.class_label = (dec > 0);
      expected_q.push_back(res);
    endfunction

    function void check_decision(logic [svmrbf_pkg::MDATA_W-1:0] data);
      decision_t exp_res;
      checked++;
      if (expected_q.size() == 0) begin
        $error("decision 0x%08h with no request waiting", data[31:0]);
        errors++;
        return;
      end
      exp_res = expected_q.pop_front();
      if (data[31:0] !== exp_res.decision) begin
        $error("decision: expected %0d, got %0d", exp_res.decision, $signed(data[31:0]));
        errors++;
      end
      if (data[32] !== exp_res.class_label) begin
        $error("class_label: expected %0d, got %0d", exp_res.class_label, data[32]);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [svmrbf_pkg::SDATA_W-1:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [svmrbf_pkg::MDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [svmrbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [svmrbf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  decision_scoreboard sb = new();
  int cycles = 0;
  int burst_left = 0;
  bit hold_req = 0;
  bit hold_done = 0;

  always #5 clk = ~clk;

  svm_rbf_decision u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** svm_rbf_decision: FAILED **");
      $finish;
    end
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_request(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) sb.check_decision(m_tdata);
    end
  end

  // receiver: modes change with the cycle counter, with one long hold
  initial begin
    int mode;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 0;
        hold_done = 1;
      end
      mode = (cycles / 200) % 4;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= $urandom_range(0, 1);
      endcase
    end
  end

  task automatic write_reg(logic [svmrbf_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_request(logic op, logic [7:0] idx, logic [15:0] w, logic [63:0] f);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tuser <= op;
    s_tdata <= {f, w, idx};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // loads make no decision, so the queue empties once the last classify has
  // been answered; wait a further margin before touching registers
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (TABLE_N + 40) @(negedge clk);
  endtask

  task automatic set_config(logic [15:0] g, logic [15:0] rho, logic [8:0] n);
    write_reg(svmrbf_pkg::REG_GAMMA, g);
    write_reg(svmrbf_pkg::REG_BIAS_RHO, rho);
    write_reg(svmrbf_pkg::REG_SV_COUNT, {7'd0, n});
  endtask

  function automatic logic [63:0] near_entry(int j);
    logic [63:0] f;
    for (int k = 0; k < 4; k++)
      f[16*k +: 16] = sb.features[j][16*k +: 16] + 16'($urandom_range(0, 4095) - 2048);
    return f;
  endfunction

  task automatic random_request(int n_used);
    logic [63:0] f;
    logic [15:0] w;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      w = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
      f = near_entry($urandom_range(0, TABLE_N - 1));
      if ($urandom_range(0, 3) == 0) f = {$urandom, $urandom};
      send_request(svmrbf_pkg::OP_LOAD, 8'($urandom), w, f);
    end else begin
      if (pick == 9 || n_used == 0) f = {$urandom, $urandom};
      else f = near_entry($urandom_range(0, n_used - 1));
      send_request(svmrbf_pkg::OP_CLASSIFY, 8'($urandom), 16'($urandom), f);
    end
  endtask

  initial begin
    logic [15:0] g, rho;
    logic [8:0] n;
    int used;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: zero count gives just the negated bias
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'h00, 16'h0000, 64'h7FFF_8000_FFFF_0000);
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'hFF, 16'hFFFF, 64'h8000_7FFF_0001_FFFF);
    settle();

    // full table at maximum weight, sample on top of every vector
    for (int i = 0; i < TABLE_N; i++)
      send_request(svmrbf_pkg::OP_LOAD, 8'(i), 16'h7FFF, 64'h1234_8000_7FFF_0000);
    settle();
    set_config(16'h0000, 16'h8000, 9'd256);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'h00, 16'h0000, 64'h1234_8000_7FFF_0000);
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'h00, 16'h0000, 64'h8000_7FFF_8000_7FFF);
    settle();
    set_config(16'hFFFF, 16'h7FFF, 9'd511);
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'h00, 16'h0000, 64'h1234_8000_7FFF_0000);
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'h00, 16'h0000, 64'h1234_8000_7FFF_0001);
    settle();

    // most negative weights push the sum toward the lower bound
    for (int i = 0; i < TABLE_N; i++)
      send_request(svmrbf_pkg::OP_LOAD, 8'(i), 16'h8000, near_entry(0));
    settle();
    set_config(16'h0001, 16'h7FFF, 9'd257);
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'h00, 16'h0000, sb.features[0]);
    send_request(svmrbf_pkg::OP_CLASSIFY, 8'h00, 16'h0000, 64'h0000_0000_0000_0000);
    settle();

    // random contents for the whole table
    for (int i = 0; i < TABLE_N; i++)
      send_request(svmrbf_pkg::OP_LOAD, 8'(i), 16'($urandom), {$urandom, $urandom});
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0: g = 16'h0000;
        1: g = 16'hFFFF;
        2: g = 16'($urandom);
        default: g = 16'($urandom_range(1, 300));
      endcase
      rho = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 4095) - 2048);
      case ($urandom_range(0, 19))
        0: n = 9'd0;
        1, 2: n = 9'($urandom_range(257, 511));
        3, 4, 5: n = 9'($urandom_range(17, 256));
        default: n = 9'($urandom_range(1, 16));
      endcase
      set_config(g, rho, n);
      used = (n > TABLE_N) ? TABLE_N : n;
      if (ph == 3) hold_req = 1;
      for (int i = 0; i < PHASE_REQUESTS; i++) random_request(used);
      settle();
    end

    $display("run covered %0d loads and %0d classifications, %0d decisions checked",
             sb.loads, sb.samples, sb.checked);
    $display("long receiver hold done: %0d, mismatches: %0d", hold_done, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** svm_rbf_decision: PASSED **");
    end else begin
      $display("** svm_rbf_decision: FAILED **");
    end
    $finish;
  end

endmodule
